/* hdl/bfc_pkg.sv */
// Package for the FIR convolver: payload structs, mode codes, sizes.
// No dependencies.
package bfc_pkg;
  localparam int BLOCK    = 256;
  localparam int CHANNELS = 2;
  localparam int MAX_TAPS = 257;
  localparam int HIST_LEN = BLOCK + MAX_TAPS;
  localparam int TAP_W    = 9;
  localparam int HPTR_W   = $clog2(HIST_LEN);
  localparam int HADDR_W  = $clog2(CHANNELS * HIST_LEN);
  localparam int ACC_W    = 48 + TAP_W + 1;

  localparam logic [1:0] MODE_AUDIO = 2'd0;
  localparam logic [1:0] MODE_COEF  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  localparam logic [1:0] OP_AUDIO = 2'd0;
  localparam logic [1:0] OP_COEF  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_MUTE  = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic               channel;
    logic [8:0]         tap_index;
    logic signed [23:0] value;
  } in_item_t;

  typedef struct packed {
    logic               out_channel;
    logic signed [23:0] out_sample;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic               channel;
    logic [8:0]         tap_index;
    logic signed [23:0] value;
  } cmd_t;
endpackage

/* hdl/bfc_front.sv */
// Front end: takes requests, classifies them, queues commands.
// Depends on bfc_pkg.
module bfc_front (
  input  logic              clk,
  input  logic              rst,
  input  bfc_pkg::in_item_t in_item,
  input  logic              push,
  output logic              full,
  input  logic [8:0]        tap_count,
  output bfc_pkg::cmd_t     cmd,
  output logic              cmd_valid,
  input  logic              cmd_take
);
  bfc_pkg::cmd_t q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       keep;
  logic       do_push;
  logic       do_pop;
  bfc_pkg::cmd_t c;

  always_comb begin
    c.channel   = in_item.channel;
    c.tap_index = in_item.tap_index;
    c.value     = in_item.value;
    c.op        = bfc_pkg::OP_AUDIO;
    keep        = 1'b0;
    unique case (in_item.mode)
      bfc_pkg::MODE_AUDIO: begin
        keep = (32'(in_item.channel) < bfc_pkg::CHANNELS);
        c.op = (tap_count == '0) ? bfc_pkg::OP_MUTE : bfc_pkg::OP_AUDIO;
      end
      bfc_pkg::MODE_COEF: begin
        keep = (32'(in_item.tap_index) < bfc_pkg::MAX_TAPS);
        c.op = bfc_pkg::OP_COEF;
      end
      bfc_pkg::MODE_FLUSH: begin
        keep = 1'b1;
        c.op = bfc_pkg::OP_FLUSH;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full      = (count == 2'd2);
  assign do_push   = push && !full && keep;
  assign do_pop    = cmd_take && (count != 2'd0);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= c;
    if (rst) begin
      count  <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

/* hdl/bfc_back.sv */
// Back end: coefficient and history memories, serial MAC, result queue.
// Depends on bfc_pkg.
module bfc_back (
  input  logic               clk,
  input  logic               rst,
  input  bfc_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  logic [8:0]         tap_count,
  output bfc_pkg::out_item_t res,
  output logic               empty,
  input  logic               pop
);
  localparam int HP = bfc_pkg::HPTR_W;
  localparam int HA = bfc_pkg::HADDR_W;
  localparam int AW = bfc_pkg::ACC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic signed [23:0] coef_mem [bfc_pkg::MAX_TAPS];
  logic signed [23:0] hist_mem [bfc_pkg::CHANNELS * bfc_pkg::HIST_LEN];
  logic [HP-1:0] hptr [bfc_pkg::CHANNELS];
  logic [HA-1:0] clr_addr;
  logic          clr_coef;
  logic [HA-1:0] h_raddr;
  logic [8:0]    k;
  logic [8:0]    taps;
  logic [HP-1:0] hidx;
  logic          ch;
  logic signed [23:0] c_rd, h_rd;
  logic signed [47:0] prod;
  logic          rd_v, pr_v;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rsum;
  logic signed [AW-21:0] y;
  bfc_pkg::out_item_t out_q [2];
  logic [1:0] ocount;
  logic       ordp, owrp;
  logic       o_push, o_pop;
  bfc_pkg::out_item_t o_data;

  assign taps  = (32'(tap_count) > bfc_pkg::MAX_TAPS) ? 9'(bfc_pkg::MAX_TAPS) : tap_count;
  assign cmd_take = (state == S_IDLE) && cmd_valid && !rst &&
                    !((cmd.op == bfc_pkg::OP_MUTE) && (ocount == 2'd2));
  assign rsum  = acc + (AW'(1) <<< 19);
  assign y     = rsum[AW-1:20];
  assign o_pop = pop && (ocount != 2'd0);
  assign empty = (ocount == 2'd0);
  assign res   = out_q[ordp];
  assign h_raddr = HA'(ch) * HA'(bfc_pkg::HIST_LEN) + HA'(hidx);

  always_comb begin
    o_push = 1'b0;
    o_data.out_channel = ch;
    o_data.out_sample  = '0;
    o_data.clipped     = 1'b0;
    if (state == S_IDLE && cmd_take && cmd.op == bfc_pkg::OP_MUTE) begin
      o_push = 1'b1;
      o_data.out_channel = cmd.channel;
    end else if (state == S_OUT && ocount != 2'd2) begin
      o_push = 1'b1;
      if (y > AW'(32'sd8388607)) begin
        o_data.out_sample = 24'sh7fffff;
        o_data.clipped = 1'b1;
      end else if (y < -AW'(32'sd8388608)) begin
        o_data.out_sample = -24'sh800000;
        o_data.clipped = 1'b1;
      end else begin
        o_data.out_sample = y[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    c_rd <= coef_mem[k];
    h_rd <= hist_mem[h_raddr];
    prod <= c_rd * h_rd;
    // the pass after reset also zeroes the coefficient table
    if (state == S_CLEAR && clr_coef && 32'(clr_addr) < bfc_pkg::MAX_TAPS)
      coef_mem[clr_addr[8:0]] <= '0;
    else if (state == S_IDLE && cmd_take && cmd.op == bfc_pkg::OP_COEF)
      coef_mem[cmd.tap_index] <= cmd.value;
    if (state == S_CLEAR)
      hist_mem[clr_addr] <= '0;
    else if (state == S_IDLE && cmd_take && cmd.op == bfc_pkg::OP_AUDIO)
      hist_mem[HA'(cmd.channel) * HA'(bfc_pkg::HIST_LEN) + HA'(hptr[cmd.channel])]
        <= cmd.value;
    if (o_push) out_q[owrp] <= o_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_coef <= 1'b1;
      for (int i = 0; i < bfc_pkg::CHANNELS; i++) hptr[i] <= '0;
      rd_v <= 1'b0;
      pr_v <= 1'b0;
      ocount <= '0;
      ordp <= 1'b0;
      owrp <= 1'b0;
      k <= '0;
      hidx <= '0;
      ch <= 1'b0;
      acc <= '0;
    end else begin
      if (o_push) owrp <= ~owrp;
      if (o_pop)  ordp <= ~ordp;
      ocount <= ocount + {1'b0, o_push} - {1'b0, o_pop};
      rd_v <= (state == S_MAC);
      pr_v <= rd_v;
      if (pr_v) acc <= acc + AW'(prod);
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            unique case (cmd.op)
              bfc_pkg::OP_FLUSH: begin
                state <= S_CLEAR;
                clr_addr <= '0;
                for (int i = 0; i < bfc_pkg::CHANNELS; i++) hptr[i] <= '0;
              end
              bfc_pkg::OP_AUDIO: begin
                ch <= cmd.channel;
                hptr[cmd.channel] <= (32'(hptr[cmd.channel]) == bfc_pkg::HIST_LEN - 1) ?
                                     '0 : hptr[cmd.channel] + 1'b1;
                // first tap reads p - BLOCK modulo ring length
                hidx <= (32'(hptr[cmd.channel]) >= bfc_pkg::BLOCK) ?
                        hptr[cmd.channel] - HP'(bfc_pkg::BLOCK) :
                        hptr[cmd.channel] + HP'(bfc_pkg::HIST_LEN - bfc_pkg::BLOCK);
                state <= S_MAC;
                k <= '0;
                acc <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          if (32'(clr_addr) == bfc_pkg::CHANNELS * bfc_pkg::HIST_LEN - 1) begin
            state    <= S_IDLE;
            clr_coef <= 1'b0;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        S_MAC: begin
          hidx <= (hidx == '0) ? HP'(bfc_pkg::HIST_LEN - 1) : hidx - 1'b1;
          k <= k + 1'b1;
          if (k == taps - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_v && !pr_v) state <= S_OUT;
        end
        S_OUT: begin
          if (ocount != 2'd2) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/block_fir_convolver_top.sv */
// Multichannel FIR convolver: one shared coefficient table, per-channel
// history delayed by BLOCK samples, Q1.23 rounded and saturated output.
// Channels: push/full request queue in, empty/pop result queue out.
// Mode 0 audio yields one result; coefficient write and flush yield none.
// An audio request holds the single multiply-accumulate unit for
// tap_count taps (tap_count capped at MAX_TAPS), reading one
// coefficient and one history word per cycle. A muted request
// (tap_count zero) yields a zero sample without using the MAC.
// A coefficient write goes straight into the table; a flush sweeps
// the history memory, CHANNELS*(BLOCK+MAX_TAPS) = 1026 words.
// After reset a clearing pass zeroes the histories and the
// coefficient table while no request is taken.
// A two-entry request queue lets the next request be taken while the
// MAC works; a two-entry result queue holds results while pop is low,
// and the MAC waits when it is full.
// tap_count is written over APB at address 0; write only while idle.
// Depends on bfc_pkg, bfc_front, bfc_back.
module block_fir_convolver_top (
  input  logic               clk,
  input  logic               rst,
  input  bfc_pkg::in_item_t  in_item,
  input  logic               push,
  output logic               full,
  output bfc_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [8:0]    tap_count;
  bfc_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_take;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {23'd0, tap_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) tap_count <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) tap_count <= pwdata[8:0];
  end

  bfc_front u_front (
    .clk, .rst, .in_item, .push, .full, .tap_count,
    .cmd, .cmd_valid, .cmd_take
  );

  bfc_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take, .tap_count,
    .res(out_item), .empty, .pop
  );
endmodule

/* hdl/bfc_checker.sv */
// Port-level checks for the FIR convolver.
// Depends on bfc_pkg; bound to block_fir_convolver_top.
module bfc_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               pready,
  input bfc_pkg::out_item_t out_item
);
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_full_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");
  a_empty_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(out_item))
    else $error("result changed while waiting");
  a_clip: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.clipped) |->
      (out_item.out_sample == 24'sh7fffff || out_item.out_sample == -24'sh800000))
    else $error("clip flag without limit value");
endmodule

bind block_fir_convolver_top bfc_checker u_bfc_checker (
  .clk, .rst, .full, .empty, .pop, .pready, .out_item
);

/* tb/bfc_output_checker.sv */
// Checker for the FIR convolver: follows tap_count writes and accepted requests,
// predicts each filtered sample and compares the result queue field by field.
// Depends on bfc_pkg.
module bfc_output_checker (
  input  logic               clk,
  input  logic               rst,
  input  bfc_pkg::in_item_t  in_item,
  input  logic               push,
  input  logic               full,
  input  bfc_pkg::out_item_t out_item,
  input  logic               empty,
  input  logic               pop,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);
  import bfc_pkg::*;

  localparam logic [1:0] ADDR_TAP_COUNT = 2'd0;

  logic signed [23:0] coef_mem [MAX_TAPS];
  logic signed [23:0] hist_mem [CHANNELS][HIST_LEN];
  int unsigned        hist_wr  [CHANNELS];
  logic [8:0]         tap_count;
  out_item_t          expected_samples [$];

  task automatic clear_history();
    for (int c = 0; c < CHANNELS; c++) begin
      hist_wr[c] = 0;
      for (int i = 0; i < HIST_LEN; i++) hist_mem[c][i] = '0;
    end
  endtask

  task automatic filter_request(input in_item_t req);
    out_item_t   res;
    int unsigned taps;
    int unsigned p;
    int unsigned idx;
    longint      acc;
    longint      y;
    case (req.mode)
      MODE_COEF: if (req.tap_index < MAX_TAPS) coef_mem[req.tap_index] = req.value;
      MODE_FLUSH: clear_history();
      MODE_AUDIO: begin
        res.out_channel = req.channel;
        res.out_sample  = '0;
        res.clipped     = 1'b0;
        taps = (tap_count > MAX_TAPS) ? MAX_TAPS : tap_count;
        if (taps != 0) begin
          p = hist_wr[req.channel];
          hist_mem[req.channel][p] = req.value;
          hist_wr[req.channel] = (p + 1) % HIST_LEN;
          acc = 0;
          for (int unsigned k = 0; k < taps; k++) begin
            idx = (p + 2 * HIST_LEN - BLOCK - k) % HIST_LEN;
            acc += longint'(hist_mem[req.channel][idx]) * longint'(coef_mem[k]);
          end
          y = (acc + (64'sd1 <<< 19)) >>> 20;
          if (y > 64'sd8388607) begin
            y = 64'sd8388607;
            res.clipped = 1'b1;
          end else if (y < -64'sd8388608) begin
            y = -64'sd8388608;
            res.clipped = 1'b1;
          end
          res.out_sample = y[23:0];
        end
        expected_samples.insert(expected_samples.size(), res);
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t exp;
    if (expected_samples.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: ch %0d sample %0d clip %0d",
                                 got.out_channel, got.out_sample, got.clipped);
      return;
    end
    exp = expected_samples.pop_front();
    if (got.out_channel !== exp.out_channel || got.out_sample !== exp.out_sample ||
        got.clipped !== exp.clipped) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp ch %0d sample %0d clip %0d, got ch %0d sample %0d clip %0d",
                 exp.out_channel, exp.out_sample, exp.clipped,
                 got.out_channel, got.out_sample, got.clipped);
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) coef_mem[i] = '0;
      clear_history();
      tap_count = '0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_TAP_COUNT)
        tap_count = pwdata[8:0];
      if (push && !full) filter_request(in_item);
      if (pop && !empty) check_result(out_item);
    end
    pending <= expected_samples.size();
  end
endmodule

/* tb/tb_block_fir_convolver_top.sv */
// Testbench top for block_fir_convolver_top: reset, tap_count settings over APB,
// directed then random requests with bursty push and stalled pop; verdict.
// Depends on bfc_pkg, the RTL and bfc_output_checker.
module tb_block_fir_convolver_top;
  import bfc_pkg::*;

  localparam int          IDLE_LIMIT     = 20000;
  localparam int          SETTLE_CYCLES  = 1100;
  localparam logic [1:0]  ADDR_TAP_COUNT = 2'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  in_item_t    in_item = '0;
  logic        push = 1'b0;
  logic        full;
  out_item_t   out_item;
  logic        empty;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          burst_left = 0;
  int          gap_max = 0;
  int          pop_style = 0;
  int          pop_timer = 0;
  int          idle_cycles = 0;

  block_fir_convolver_top i_dut (
    .clk, .rst, .in_item, .push, .full, .out_item, .empty, .pop,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bfc_output_checker i_checker (
    .clk, .rst, .in_item, .push, .full, .out_item, .empty, .pop,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
  );

  initial forever #5 clk = ~clk;

  // pop pattern: free running, coin flip, or long stalls
  always @(posedge clk) begin
    if (pop_timer == 0) begin
      pop_style <= $urandom_range(0, 2);
      pop_timer <= $urandom_range(50, 400);
    end else begin
      pop_timer <= pop_timer - 1;
    end
    case (pop_style)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      default: pop <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(input in_item_t req);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_item <= req;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    burst_left--;
  endtask

  task automatic send_fields(input logic [1:0] mode, input logic ch,
                             input logic [8:0] tix, input logic [23:0] val);
    in_item_t req;
    req.mode      = mode;
    req.channel   = ch;
    req.tap_index = tix;
    req.value     = val;
    send(req);
  endtask

  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [8:0] taps);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TAP_COUNT;
    pwdata  <= {23'd0, taps};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [23:0] pick_value(input bit coef);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 24'h7FFFFF;
    if (sel == 1) return 24'h800000;
    if (coef && sel < 6) return 24'($urandom_range(0, 8191) - 4096);
    return 24'($urandom);
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int r;
    r = $urandom_range(0, 99);
    if (r < 84)      req.mode = MODE_AUDIO;
    else if (r < 94) req.mode = MODE_COEF;
    else if (r < 95) req.mode = MODE_FLUSH;
    else             req.mode = OP_MUTE;
    req.channel   = 1'($urandom_range(0, 1));
    req.tap_index = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                               : 9'($urandom_range(0, 256));
    req.value     = pick_value(req.mode == MODE_COEF);
    return req;
  endfunction

  initial begin
    logic [8:0] settings [8];
    settings = '{9'd1, 9'd257, 9'd511, 9'd2, 9'd256, 9'd300, 9'd0, 9'd0};
    settings[7] = 9'($urandom_range(3, 40));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_tap_count(9'd0);

    // muted audio, coefficient extremes, ignored indexes, unused mode, flush
    gap_max = 3;
    send_fields(MODE_AUDIO, 1'b0, 9'd0, 24'h7FFFFF);
    send_fields(MODE_AUDIO, 1'b1, 9'd511, 24'h800000);
    send_fields(MODE_COEF, 1'b0, 9'd0, 24'h7FFFFF);
    send_fields(MODE_COEF, 1'b1, 9'd256, 24'h800000);
    send_fields(MODE_COEF, 1'b0, 9'd1, 24'h100000);
    send_fields(MODE_COEF, 1'b0, 9'd257, 24'h7FFFFF);
    send_fields(MODE_COEF, 1'b1, 9'd511, 24'h123456);
    send_fields(OP_MUTE, 1'b1, 9'd5, 24'h7FFFFF);
    send_fields(MODE_AUDIO, 1'b0, 9'd0, 24'h000001);
    send_fields(MODE_FLUSH, 1'b0, 9'd0, 24'h0);
    drain();
    write_tap_count(9'd2);
    for (int i = 0; i < 12; i++)
      send_fields(MODE_AUDIO, i[0], 9'd0, (i % 3 == 0) ? 24'h7FFFFF : 24'h800000);
    send_fields(MODE_FLUSH, 1'b1, 9'd0, 24'hFFFFFF);
    send_fields(MODE_AUDIO, 1'b1, 9'd0, 24'hFFFFFF);

    foreach (settings[s]) begin
      drain();
      write_tap_count(settings[s]);
      gap_max = (s % 3 == 1) ? 0 : $urandom_range(1, 12);
      for (int n = 0; n < 135; n++) send(random_request());
    end

    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
